[rtl/imu_stream_alignment_unit_assert.svh]
// assertion macros shared by the imu stream alignment rtl
// expects clk and arst_n in the scope of each use
`ifndef IMU_STREAM_ALIGNMENT_UNIT_ASSERT_SVH
`define IMU_STREAM_ALIGNMENT_UNIT_ASSERT_SVH

// condition that holds at every clock edge out of reset
`define IASU_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// same-cycle implication
`define IASU_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/iasu_pkg.sv]
// types and constants of the imu stream alignment unit
// no dependencies; imported by every rtl module of the block
package iasu_pkg;

	localparam int StampW   = 48;
	localparam int AxisW    = 32;
	localparam int NumAxes  = 3;
	localparam int FracW    = 16;
	localparam int RunLimit = 16;

	typedef logic [StampW-1:0] stamp_t;

	typedef enum logic {
		OP_GYRO  = 1'b0,
		OP_ACCEL = 1'b1
	} op_t;

	// one timestamped three-axis sample
	typedef struct packed {
		stamp_t                             stamp;
		logic [NumAxes-1:0][AxisW-1:0]      val;
	} sample_t;

	typedef struct packed {
		op_t     op;
		sample_t smp;
	} item_t;

	// one fused output beat
	typedef struct packed {
		stamp_t                        stamp;
		logic [NumAxes-1:0][AxisW-1:0] rate;
		logic [NumAxes-1:0][AxisW-1:0] accel;
		logic                          last;
	} result_t;

	typedef struct packed {
		logic   start;
		stamp_t num;
		stamp_t den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [FracW-1:0] quo;
	} div_rsp_t;

endpackage

[rtl/iasu_front.sv]
// input side of the imu stream alignment unit: takes sample beats into a short queue
// depends on iasu_pkg
module iasu_front import iasu_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	output logic  deq_valid,
	input  logic  deq_ready,
	output item_t deq_item
);

	localparam int QDepth = 2;

	item_t      buf_q [QDepth];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	// queue status
	assign in_ready  = (cnt_q != 2'(QDepth));
	assign deq_valid = (cnt_q != 2'd0);
	assign deq_item  = buf_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = deq_valid && deq_ready;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	// beat storage
	always_ff @(posedge clk) begin
		if (push) buf_q[wr_q] <= in_item;
	end

endmodule

[rtl/iasu_div.sv]
// restoring divider for the q0.16 interpolation weight, one quotient bit a cycle
// depends on iasu_pkg; expects num < den
module iasu_div import iasu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [StampW:0]  rem_q;
	stamp_t           den_q;
	logic [FracW-1:0] quo_q;
	logic [3:0]       cnt_q;
	logic             act_q;
	logic             done_q;
	logic [StampW:0]  shifted;
	logic             ge;

	// one restoring step
	assign shifted = {rem_q[StampW-1:0], 1'b0};
	assign ge      = (shifted >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			den_q  <= '0;
			quo_q  <= '0;
			cnt_q  <= '0;
			act_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				rem_q <= {1'b0, req.num};
				den_q <= req.den;
				quo_q <= '0;
				cnt_q <= '0;
				act_q <= 1'b1;
			end else if (act_q) begin
				rem_q <= ge ? (shifted - {1'b0, den_q}) : shifted;
				quo_q <= {quo_q[FracW-2:0], ge};
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'(FracW - 1)) begin
					act_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

[rtl/iasu_engine.sv]
// back end of the imu stream alignment unit: sample rings, release walk,
// interpolation and the output register; depends on iasu_pkg and the assert macros
`include "imu_stream_alignment_unit_assert.svh"
module iasu_engine import iasu_pkg::*; #(
	parameter int GYRO_DEPTH  = 16,
	parameter int ACCEL_DEPTH = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     deq_valid,
	output logic     deq_ready,
	input  item_t    deq_item,
	output div_req_t div_req,
	input  div_rsp_t div_rsp,
	output logic     out_valid,
	input  logic     out_ready,
	output result_t  out_res
);

	localparam int GW = $clog2(GYRO_DEPTH);
	localparam int AW = (ACCEL_DEPTH > 1) ? $clog2(ACCEL_DEPTH) : 1;

	typedef enum logic [4:0] {
		S_IDLE, S_G_START, S_G_CMP, S_G_G0, S_CALC, S_DIV, S_MUL, S_ADD, S_EMIT,
		S_G_TR0, S_G_TR1, S_G_PUSH, S_A_START, S_A_H, S_A_T, S_A_W0, S_A_W1,
		S_A_P0, S_A_P1, S_A_P2, S_FIN
	} state_t;

	state_t                         state_q;
	item_t                          it_q;
	logic [GW-1:0]                  ghead_q;
	logic [GW:0]                    gcount_q;
	logic [AW-1:0]                  ahead_q;
	logic [AW:0]                    acount_q;
	logic [4:0]                     n_q;
	logic [1:0]                     k_q;
	stamp_t                         rs_stamp_q;
	stamp_t                         ta_q;
	stamp_t                         num_q;
	stamp_t                         den_q;
	logic [FracW:0]                 lam_q;
	logic [NumAxes-1:0][AxisW-1:0]  ra_q;
	logic [NumAxes-1:0][AxisW-1:0]  rb_q;
	logic [NumAxes-1:0][AxisW-1:0]  w_q;
	logic [NumAxes-1:0][AxisW-1:0]  acc_q;
	logic signed [50:0]             prod_q;
	logic                           div_start_q;
	result_t                        pend_q;
	logic                           pend_v_q;
	result_t                        out_res_q;
	logic                           out_valid_q;

	sample_t                        gmem [GYRO_DEPTH];
	sample_t                        amem [ACCEL_DEPTH];
	sample_t                        grd_q;
	sample_t                        ard_q;

	stamp_t                         it_t;
	logic [GW:0]                    g_h1_sum;
	logic [GW:0]                    g_tl_sum;
	logic [GW:0]                    g_pc_sum;
	logic [GW-1:0]                  g_h1;
	logic [GW-1:0]                  g_tl;
	logic [GW-1:0]                  g_pc;
	logic [AW:0]                    a_h1_sum;
	logic [AW:0]                    a_tl_sum;
	logic [AW-1:0]                  a_h1;
	logic [AW-1:0]                  a_tl;
	logic [GW-1:0]                  g_raddr;
	logic                           g_full;
	logic                           gwe;
	logic [GW-1:0]                  gwaddr;
	logic                           awe;
	logic signed [32:0]             diff_k;
	logic signed [50:0]             prod_c;
	logic                           out_free;

	assign it_t = it_q.smp.stamp;

	// ring index arithmetic, wrapping at the ring depth
	assign g_h1_sum = {1'b0, ghead_q} + (GW+1)'(1);
	assign g_tl_sum = {1'b0, ghead_q} + gcount_q - (GW+1)'(1);
	assign g_pc_sum = {1'b0, ghead_q} + gcount_q;
	assign g_h1 = (g_h1_sum >= (GW+1)'(GYRO_DEPTH)) ?
		GW'(g_h1_sum - (GW+1)'(GYRO_DEPTH)) : g_h1_sum[GW-1:0];
	assign g_tl = (g_tl_sum >= (GW+1)'(GYRO_DEPTH)) ?
		GW'(g_tl_sum - (GW+1)'(GYRO_DEPTH)) : g_tl_sum[GW-1:0];
	assign g_pc = (g_pc_sum >= (GW+1)'(GYRO_DEPTH)) ?
		GW'(g_pc_sum - (GW+1)'(GYRO_DEPTH)) : g_pc_sum[GW-1:0];
	assign a_h1_sum = {1'b0, ahead_q} + (AW+1)'(1);
	assign a_tl_sum = {1'b0, ahead_q} + acount_q;
	assign a_h1 = (a_h1_sum >= (AW+1)'(ACCEL_DEPTH)) ?
		AW'(a_h1_sum - (AW+1)'(ACCEL_DEPTH)) : a_h1_sum[AW-1:0];
	assign a_tl = (a_tl_sum >= (AW+1)'(ACCEL_DEPTH)) ?
		AW'(a_tl_sum - (AW+1)'(ACCEL_DEPTH)) : a_tl_sum[AW-1:0];
	assign g_full = (gcount_q == (GW+1)'(GYRO_DEPTH));

	// gyro read address follows the walk state
	always_comb begin
		case (state_q)
			S_A_H:          g_raddr = g_tl;
			S_A_W0, S_A_P1: g_raddr = g_h1;
			default:        g_raddr = ghead_q;
		endcase
	end

	// ring writes
	assign gwe    = (state_q == S_G_PUSH);
	assign gwaddr = g_full ? ghead_q : g_pc;
	assign awe    = (state_q == S_A_T) && (it_t > grd_q.stamp) &&
		(acount_q < (AW+1)'(ACCEL_DEPTH));

	always_ff @(posedge clk) begin
		if (gwe) gmem[gwaddr] <= it_q.smp;
		if (awe) amem[a_tl] <= it_q.smp;
		grd_q <= gmem[g_raddr];
		ard_q <= amem[ahead_q];
	end

	// one axis of the interpolation product
	assign diff_k = $signed({rb_q[k_q][AxisW-1], rb_q[k_q]}) -
		$signed({ra_q[k_q][AxisW-1], ra_q[k_q]});
	assign prod_c = diff_k * $signed({1'b0, lam_q});

	assign out_free  = !out_valid_q || out_ready;
	assign deq_ready = (state_q == S_IDLE);

	// sequencer, pending result and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			it_q        <= '0;
			ghead_q     <= '0;
			gcount_q    <= '0;
			ahead_q     <= '0;
			acount_q    <= '0;
			n_q         <= '0;
			k_q         <= '0;
			rs_stamp_q  <= '0;
			ta_q        <= '0;
			num_q       <= '0;
			den_q       <= '0;
			lam_q       <= '0;
			ra_q        <= '0;
			rb_q        <= '0;
			w_q         <= '0;
			acc_q       <= '0;
			prod_q      <= '0;
			div_start_q <= 1'b0;
			pend_q      <= '0;
			pend_v_q    <= 1'b0;
			out_res_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (deq_valid) begin
						it_q    <= deq_item;
						n_q     <= '0;
						state_q <= (deq_item.op == OP_ACCEL) ? S_A_START : S_G_START;
					end
				end
				// gyro beat: walk pending accel samples
				S_G_START: state_q <= (acount_q == '0) ? S_G_PUSH : S_G_CMP;
				S_G_CMP: begin
					if (n_q == '0 && it_t < ard_q.stamp) begin
						gcount_q <= '0;
						ghead_q  <= '0;
						state_q  <= S_G_PUSH;
					end else if (n_q != 5'(RunLimit) && it_t >= ard_q.stamp) begin
						rs_stamp_q <= ard_q.stamp;
						acc_q      <= ard_q.val;
						rb_q       <= it_q.smp.val;
						if (gcount_q == '0) begin
							w_q     <= it_q.smp.val;
							state_q <= S_EMIT;
						end else begin
							state_q <= S_G_G0;
						end
					end else begin
						state_q <= S_G_TR0;
					end
				end
				S_G_G0: begin
					ra_q    <= grd_q.val;
					num_q   <= (rs_stamp_q > grd_q.stamp) ? rs_stamp_q - grd_q.stamp : '0;
					den_q   <= (it_t > grd_q.stamp) ? it_t - grd_q.stamp : '0;
					state_q <= S_CALC;
				end
				// weight: saturated or from the divider
				S_CALC: begin
					k_q <= '0;
					if (num_q >= den_q) begin
						lam_q   <= (FracW+1)'(1) << FracW;
						state_q <= S_MUL;
					end else begin
						div_start_q <= 1'b1;
						state_q     <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						lam_q   <= {1'b0, div_rsp.quo};
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					prod_q  <= prod_c;
					state_q <= S_ADD;
				end
				S_ADD: begin
					w_q[k_q] <= ra_q[k_q] + prod_q[FracW+AxisW-1:FracW];
					if (k_q == 2'(NumAxes - 1)) begin
						state_q <= S_EMIT;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= S_MUL;
					end
				end
				// hold one result back so the last one of a run can be marked
				S_EMIT: begin
					if (!pend_v_q || out_free) begin
						if (pend_v_q) begin
							out_res_q   <= pend_q;
							out_valid_q <= 1'b1;
						end
						pend_q.stamp <= rs_stamp_q;
						pend_q.rate  <= w_q;
						pend_q.accel <= acc_q;
						pend_q.last  <= 1'b0;
						pend_v_q     <= 1'b1;
						if (it_q.op == OP_GYRO) begin
							ahead_q  <= a_h1;
							acount_q <= acount_q - (AW+1)'(1);
							n_q      <= n_q + 5'd1;
							state_q  <= S_G_START;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				// drop gyro entries older than the new one while accel samples wait
				S_G_TR0: state_q <= S_G_TR1;
				S_G_TR1: begin
					if (gcount_q != '0 && grd_q.stamp < it_t) begin
						ghead_q  <= g_h1;
						gcount_q <= gcount_q - (GW+1)'(1);
						state_q  <= S_G_TR0;
					end else begin
						state_q <= S_G_PUSH;
					end
				end
				S_G_PUSH: begin
					if (g_full) ghead_q <= g_h1;
					else gcount_q <= gcount_q + (GW+1)'(1);
					state_q <= S_FIN;
				end
				// accel beat
				S_A_START: state_q <= (gcount_q == '0) ? S_FIN : S_A_H;
				S_A_H: state_q <= (it_t < grd_q.stamp) ? S_FIN : S_A_T;
				S_A_T: begin
					if (it_t > grd_q.stamp) begin
						ghead_q  <= g_tl;
						gcount_q <= (GW+1)'(1);
						if (acount_q < (AW+1)'(ACCEL_DEPTH)) acount_q <= acount_q + (AW+1)'(1);
						state_q <= S_FIN;
					end else if (it_t == grd_q.stamp) begin
						ghead_q    <= g_tl;
						gcount_q   <= (GW+1)'(1);
						rs_stamp_q <= it_t;
						w_q        <= grd_q.val;
						acc_q      <= it_q.smp.val;
						state_q    <= S_EMIT;
					end else begin
						state_q <= S_A_W0;
					end
				end
				S_A_W0: state_q <= S_A_W1;
				S_A_W1: begin
					if (gcount_q > (GW+1)'(2) && it_t >= grd_q.stamp) begin
						ghead_q  <= g_h1;
						gcount_q <= gcount_q - (GW+1)'(1);
						state_q  <= S_A_W0;
					end else begin
						state_q <= S_A_P0;
					end
				end
				S_A_P0: state_q <= S_A_P1;
				S_A_P1: begin
					ta_q    <= grd_q.stamp;
					ra_q    <= grd_q.val;
					state_q <= S_A_P2;
				end
				S_A_P2: begin
					rb_q       <= grd_q.val;
					num_q      <= (it_t > ta_q) ? it_t - ta_q : '0;
					den_q      <= (grd_q.stamp > ta_q) ? grd_q.stamp - ta_q : '0;
					rs_stamp_q <= it_t;
					acc_q      <= it_q.smp.val;
					state_q    <= S_CALC;
				end
				// flush the held result with the end-of-run mark
				S_FIN: begin
					if (!pend_v_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						out_res_q      <= pend_q;
						out_res_q.last <= 1'b1;
						out_valid_q    <= 1'b1;
						pend_v_q       <= 1'b0;
						state_q        <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign div_req.start = div_start_q;
	assign div_req.num   = num_q;
	assign div_req.den   = den_q;
	assign out_valid     = out_valid_q;
	assign out_res       = out_res_q;

	`IASU_ASSERT_ALWAYS(a_gyro_fill, gcount_q <= (GW+1)'(GYRO_DEPTH), "gyro fill beyond depth")
	`IASU_ASSERT_ALWAYS(a_accel_fill, acount_q <= (AW+1)'(ACCEL_DEPTH), "accel fill beyond depth")
	`IASU_ASSERT_IMPLY(a_idle_flushed, state_q == S_IDLE, !pend_v_q, "result held across beats")
	`IASU_ASSERT_IMPLY(a_div_owner, div_rsp.done, state_q == S_DIV, "divider done out of turn")

endmodule

[rtl/imu_stream_alignment_unit.sv]
// Top level of the imu stream alignment unit.
// Input channel: in_valid/in_ready with opcode (0 gyro, 1 accel), stamp, axis_x/y/z.
// Output channel: out_valid/out_ready with fused_stamp, rate_x/y/z, accel_x/y/z and
// last_of_run, which marks the final fused beat caused by one input beat.
// A two-entry input queue takes beats while the back end works on an earlier one;
// the back end handles one beat at a time and takes a beat only in its idle state.
// Gyro beat: releases the waiting accel beats that are not newer than it, with the rate
// interpolated (through the divider unless the weight saturates, taken from the gyro
// beat itself with the gyro ring empty); it empties the gyro ring when the oldest waiting
// accel beat is newer, and discards older gyro entries when accel beats stay waiting
// after a release. Accel beat: dropped when the gyro ring is empty or it is older than
// every gyro entry; it waits when newer than every entry, is fused on the newest gyro
// stamp, and else interpolates after discarding gyro entries. The divider holds the
// back end until it is done, and the shared multiplier works through the axes in turn.
// One fused beat waits in a holding register and one in the output register, so a
// stalled receiver stops the back end after two results; input beats then back up
// in the input queue and in_ready falls.
// Reset (arst_n low) empties both rings, the queue and the output; ring contents
// are left as they are and never read before being written.
module imu_stream_alignment_unit import iasu_pkg::*; #(
	parameter int GYRO_DEPTH  = 16,
	parameter int ACCEL_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               opcode,
	input  logic [47:0]        stamp,
	input  logic signed [31:0] axis_x,
	input  logic signed [31:0] axis_y,
	input  logic signed [31:0] axis_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [47:0]        fused_stamp,
	output logic signed [31:0] rate_x,
	output logic signed [31:0] rate_y,
	output logic signed [31:0] rate_z,
	output logic signed [31:0] accel_x,
	output logic signed [31:0] accel_y,
	output logic signed [31:0] accel_z,
	output logic               last_of_run
);

	item_t    in_item;
	item_t    deq_item;
	logic     deq_valid;
	logic     deq_ready;
	div_req_t div_req;
	div_rsp_t div_rsp;
	result_t  out_res;

	// pack the input beat
	assign in_item.op            = op_t'(opcode);
	assign in_item.smp.stamp     = stamp;
	assign in_item.smp.val[0]    = axis_x;
	assign in_item.smp.val[1]    = axis_y;
	assign in_item.smp.val[2]    = axis_z;

	iasu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.deq_valid (deq_valid),
		.deq_ready (deq_ready),
		.deq_item  (deq_item)
	);

	iasu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	iasu_engine #(
		.GYRO_DEPTH  (GYRO_DEPTH),
		.ACCEL_DEPTH (ACCEL_DEPTH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.deq_valid (deq_valid),
		.deq_ready (deq_ready),
		.deq_item  (deq_item),
		.div_req   (div_req),
		.div_rsp   (div_rsp),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	// unpack the output beat
	assign fused_stamp = out_res.stamp;
	assign rate_x      = out_res.rate[0];
	assign rate_y      = out_res.rate[1];
	assign rate_z      = out_res.rate[2];
	assign accel_x     = out_res.accel[0];
	assign accel_y     = out_res.accel[1];
	assign accel_z     = out_res.accel[2];
	assign last_of_run = out_res.last;

endmodule

[tb/sv/imu_stream_alignment_unit_checker.sv]
// checker for the imu stream alignment unit: watches both channels, predicts fused beats
// depends on iasu_pkg for the opcode enum and RunLimit
module imu_stream_alignment_unit_checker import iasu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               opcode,
	input  logic [47:0]        stamp,
	input  logic signed [31:0] axis_x,
	input  logic signed [31:0] axis_y,
	input  logic signed [31:0] axis_z,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [47:0]        fused_stamp,
	input  logic signed [31:0] rate_x,
	input  logic signed [31:0] rate_y,
	input  logic signed [31:0] rate_z,
	input  logic signed [31:0] accel_x,
	input  logic signed [31:0] accel_y,
	input  logic signed [31:0] accel_z,
	input  logic               last_of_run,
	output int                 fail_count,
	output int                 pending_fused,
	output int                 fused_seen,
	output int                 beats_in
);

	localparam int GDepth = 16;
	localparam int ADepth = 16;

	typedef struct {
		logic [47:0]        t;
		logic signed [31:0] r [3];
		logic signed [31:0] a [3];
		logic               last;
	} fused_t;

	fused_t fused_q[$];

	logic [47:0]        gy_t [GDepth];
	logic signed [31:0] gy_v [GDepth][3];
	int                 gy_head, gy_cnt;
	logic [47:0]        ac_t [ADepth];
	logic signed [31:0] ac_v [ADepth][3];
	int                 ac_head, ac_cnt;

	function automatic longint unsigned frac_q16(longint unsigned num, longint unsigned den);
		if (num >= den)
			return 65536;
		return (num << 16) / den;
	endfunction

	function automatic logic signed [31:0] blend(longint signed lo, longint signed hi,
			longint unsigned lam);
		longint signed p, q;
		p = (hi - lo) * longint'(lam);
		q = (p >= 0) ? p / 65536 : -((-p + 65535) / 65536);
		return 32'(lo + q);
	endfunction

	function automatic int gs(int i);
		return (gy_head + i) % GDepth;
	endfunction

	function automatic int as_(int i);
		return (ac_head + i) % ADepth;
	endfunction

	task automatic gyro_drop();
		if (gy_cnt > 0) begin
			gy_head = (gy_head + 1) % GDepth;
			gy_cnt--;
		end
	endtask

	task automatic push_fused(logic [47:0] t, logic signed [31:0] r [3],
			logic signed [31:0] a [3]);
		fused_t f;
		f.t = t;
		f.r = r;
		f.a = a;
		f.last = 1'b0;
		fused_q = {fused_q, f};
	endtask

	// model of one accepted input beat
	task automatic predict_beat(op_t op, logic [47:0] t, logic signed [31:0] v [3]);
		int n, s, g0, g1;
		longint unsigned lam, t0;
		logic signed [31:0] w [3];
		n = 0;
		if (op == OP_GYRO) begin
			if (ac_cnt > 0) begin
				if (t < ac_t[as_(0)]) begin
					gy_cnt = 0;
					gy_head = 0;
				end else begin
					while (ac_cnt > 0 && n < RunLimit && t >= ac_t[as_(0)]) begin
						s = as_(0);
						if (gy_cnt == 0) begin
							w = v;
						end else begin
							g0 = gs(0);
							t0 = gy_t[g0];
							lam = frac_q16(ac_t[s] > t0 ? ac_t[s] - t0 : 0,
								t > t0 ? t - t0 : 0);
							for (int i = 0; i < 3; i++)
								w[i] = blend(gy_v[g0][i], v[i], lam);
						end
						push_fused(ac_t[s], w, ac_v[s]);
						n++;
						ac_head = (ac_head + 1) % ADepth;
						ac_cnt--;
					end
					if (ac_cnt > 0)
						while (gy_cnt > 0 && gy_t[gs(0)] < t)
							gyro_drop();
				end
			end
			if (gy_cnt >= GDepth)
				gyro_drop();
			s = gs(gy_cnt);
			gy_t[s] = t;
			gy_v[s] = v;
			gy_cnt++;
		end else if (gy_cnt != 0 && t >= gy_t[gs(0)]) begin
			if (t > gy_t[gs(gy_cnt - 1)]) begin
				while (gy_cnt > 1)
					gyro_drop();
				if (ac_cnt < ADepth) begin
					s = as_(ac_cnt);
					ac_t[s] = t;
					ac_v[s] = v;
					ac_cnt++;
				end
			end else if (t == gy_t[gs(gy_cnt - 1)]) begin
				while (gy_cnt > 1)
					gyro_drop();
				push_fused(t, gy_v[gs(0)], v);
				n = 1;
			end else begin
				while (gy_cnt > 2 && t >= gy_t[gs(1)])
					gyro_drop();
				g0 = gs(0);
				g1 = gs(1);
				t0 = gy_t[g0];
				lam = frac_q16(t > t0 ? t - t0 : 0,
					gy_t[g1] > t0 ? gy_t[g1] - t0 : 0);
				for (int i = 0; i < 3; i++)
					w[i] = blend(gy_v[g0][i], gy_v[g1][i], lam);
				push_fused(t, w, v);
				n = 1;
			end
		end
		if (n > 0)
			fused_q[$].last = 1'b1;
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch on %s: got %0h expected %0h", what, got, want);
		fail_count++;
	endtask

	// compare one output beat with the oldest prediction
	task automatic check_fused();
		fused_t e;
		logic signed [31:0] gr [3];
		logic signed [31:0] ga [3];
		gr = '{rate_x, rate_y, rate_z};
		ga = '{accel_x, accel_y, accel_z};
		if (fused_q.size() == 0) begin
			report_mismatch("unexpected fused beat stamp", fused_stamp, 0);
			return;
		end
		e = fused_q[0];
		fused_q.delete(0);
		if (fused_stamp !== e.t)
			report_mismatch("fused_stamp", fused_stamp, e.t);
		for (int i = 0; i < 3; i++) begin
			if (gr[i] !== e.r[i])
				report_mismatch($sformatf("rate axis %0d", i), gr[i], e.r[i]);
			if (ga[i] !== e.a[i])
				report_mismatch($sformatf("accel axis %0d", i), ga[i], e.a[i]);
		end
		if (last_of_run !== e.last)
			report_mismatch("last_of_run", last_of_run, e.last);
	endtask

	// sample both channels at each rising edge
	always @(posedge clk or negedge arst_n) begin
		logic signed [31:0] v [3];
		if (!arst_n) begin
			fused_q.delete();
			gy_head = 0;
			gy_cnt = 0;
			ac_head = 0;
			ac_cnt = 0;
			fail_count = 0;
			fused_seen = 0;
			beats_in = 0;
		end else begin
			if (out_valid && out_ready) begin
				check_fused();
				fused_seen++;
			end
			if (in_valid && in_ready) begin
				v = '{axis_x, axis_y, axis_z};
				predict_beat(op_t'(opcode), stamp, v);
				beats_in++;
			end
		end
		pending_fused = fused_q.size();
	end

endmodule

[tb/sv/imu_stream_alignment_unit_tb.sv]
// testbench top for the imu stream alignment unit: stimulus, stalls and verdict
// depends on iasu_pkg, the rtl top and imu_stream_alignment_unit_checker
module imu_stream_alignment_unit_tb import iasu_pkg::*; ();

	logic               clk, arst_n;
	logic               in_valid, in_ready, opcode;
	logic [47:0]        stamp;
	logic signed [31:0] axis_x, axis_y, axis_z;
	logic               out_valid, out_ready;
	logic [47:0]        fused_stamp;
	logic signed [31:0] rate_x, rate_y, rate_z, accel_x, accel_y, accel_z;
	logic               last_of_run;
	int                 fail_count, pending_fused, fused_seen, beats_in;
	int                 send_idle_pct, recv_idle_pct, hold_cycles, quiet_cycles;
	logic               hold_arm, hold_used;
	logic [47:0]        gyro_clock, accel_clock;

	localparam int QuietLimit = 20000;
	localparam int HoldLen    = 1500;

	imu_stream_alignment_unit dut (.*);

	imu_stream_alignment_unit_checker chk (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// receiver: random stalls plus one long hold-off once armed
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready   <= 1'b0;
			hold_cycles <= 0;
			hold_used   <= 1'b0;
		end else if (hold_arm && !hold_used) begin
			hold_used   <= 1'b1;
			hold_cycles <= HoldLen - 1;
			out_ready   <= 1'b0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready   <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog on cycles with no accepted beat
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QuietLimit) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic send_beat(op_t op, logic [47:0] t, logic [31:0] x, logic [31:0] y,
			logic [31:0] z);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		stamp <= t;
		axis_x <= x;
		axis_y <= y;
		axis_z <= z;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic send_rand(op_t op, logic [47:0] t);
		send_beat(op, t, $urandom, $urandom, $urandom);
	endtask

	// one well-formed stretch: gyro beats with accel beats between and after them
	task automatic sensor_stretch(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(2) == 0) begin
				gyro_clock = gyro_clock + $urandom_range(0, 40);
				send_rand(OP_GYRO, gyro_clock);
			end else begin
				case ($urandom_range(4))
					0: accel_clock = gyro_clock;
					1: accel_clock = gyro_clock - $urandom_range(0, 60);
					default: accel_clock = gyro_clock + $urandom_range(0, 50);
				endcase
				send_rand(OP_ACCEL, accel_clock);
			end
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_fused != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = 1'b0;
		stamp = '0;
		axis_x = '0;
		axis_y = '0;
		axis_z = '0;
		hold_arm = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: accel before any gyro, extremes, equal stamps, zero span, out of order
		send_beat(OP_ACCEL, 48'd5, 32'h1, 32'h2, 32'h3);
		send_beat(OP_GYRO, 48'd100, 32'h7fffffff, 32'h80000000, 32'h0);
		send_beat(OP_GYRO, 48'd200, 32'h80000000, 32'h7fffffff, 32'hffffffff);
		send_beat(OP_ACCEL, 48'd150, 32'h7fffffff, 32'h80000000, 32'h0);
		send_beat(OP_ACCEL, 48'd50, 32'h5, 32'h6, 32'h7);
		send_beat(OP_ACCEL, 48'd200, 32'hffffffff, 32'h0, 32'h1);
		send_beat(OP_GYRO, 48'd200, 32'h12345678, 32'hedcba987, 32'h55555555);
		send_beat(OP_ACCEL, 48'd200, 32'haaaaaaaa, 32'h1, 32'h2);
		for (int i = 0; i < 17; i++)
			send_rand(OP_ACCEL, 48'd300 + i);
		send_beat(OP_GYRO, 48'd250, 32'h3, 32'h4, 32'h5);
		send_beat(OP_GYRO, 48'hffffffff0000, 32'h80000000, 32'h7fffffff, 32'h1);
		send_beat(OP_ACCEL, 48'hfffffffffff0, 32'h1, 32'h2, 32'h3);
		send_beat(OP_GYRO, 48'hffffffffffff, 32'h7fffffff, 32'h80000000, 32'h0);
		drain();

		gyro_clock = 48'd1000;
		send_rand(OP_GYRO, gyro_clock);
		for (int i = 0; i < 18; i++)
			send_rand(OP_ACCEL, gyro_clock + 1 + i);
		send_rand(OP_GYRO, gyro_clock + 100);
		send_rand(OP_GYRO, gyro_clock + 120);
		gyro_clock = gyro_clock + 120;

		// random, three idling phases with a long receiver hold-off in the first
		send_idle_pct = 36;
		recv_idle_pct = 54;
		hold_arm = 1'b1;
		sensor_stretch(110);
		send_idle_pct = 54;
		recv_idle_pct = 36;
		sensor_stretch(110);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		sensor_stretch(80);
		for (int i = 0; i < 20; i++)
			send_rand(op_t'($urandom_range(1)), 48'({$urandom, $urandom}));
		drain();

		$display("%0d input beats and %0d fused beats checked, covering drops, full rings,",
			beats_in, fused_seen);
		$display("equal and out-of-order stamps, long runs and stalled output");
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[imu_stream_alignment_unit.f]
+incdir+rtl
rtl/iasu_pkg.sv
rtl/iasu_front.sv
rtl/iasu_div.sv
rtl/iasu_engine.sv
rtl/imu_stream_alignment_unit.sv
tb/sv/imu_stream_alignment_unit_checker.sv
tb/sv/imu_stream_alignment_unit_tb.sv
